>>> rtl/core/flc_pkg.sv
// shared types and codes for the failover lockdown controller
package flc_pkg;

  localparam int REQ_W    = 2;
  localparam int MODE_W   = 3;
  localparam int LS_W     = 3;
  localparam int THRESH_W = 8;
  localparam int CNT_OUT_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ARM    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISARM = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLOSED = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACKUP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEAKY  = 3'd3;

  localparam logic [LS_W-1:0] LS_INACTIVE = 3'd0;
  localparam logic [LS_W-1:0] LS_HEALTHY  = 3'd1;
  localparam logic [LS_W-1:0] LS_TRIPPED  = 3'd2;
  localparam logic [LS_W-1:0] LS_FAILOVER = 3'd3;
  localparam logic [LS_W-1:0] LS_OPEN     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUV      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCC_THR = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                start_blocked;
    logic [THRESH_W-1:0] trip_limit;
    logic [THRESH_W-1:0] restore_limit;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             healthy;
    logic             engage_ok;
  } req_t;

  typedef struct packed {
    logic [LS_W-1:0]      lock_state;
    logic                 block_enable;
    logic                 state_changed;
    logic                 status;
    logic [CNT_OUT_W-1:0] fail_count;
    logic [CNT_OUT_W-1:0] success_count;
  } rsp_t;

endpackage

>>> rtl/core/flc_ifs.sv
// valid/ready channel interfaces for request and result words
interface flc_req_if;
  logic                      valid;
  logic                      ready;
  logic [flc_pkg::REQ_W-1:0] req_type;
  logic                      healthy;
  logic                      engage_ok;

  modport source (output valid, output req_type, output healthy, output engage_ok,
                  input ready);
  modport sink   (input valid, input req_type, input healthy, input engage_ok,
                  output ready);
endinterface

interface flc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [flc_pkg::LS_W-1:0]      lock_state;
  logic                          block_enable;
  logic                          state_changed;
  logic                          status;
  logic [flc_pkg::CNT_OUT_W-1:0] fail_count;
  logic [flc_pkg::CNT_OUT_W-1:0] success_count;

  modport source (output valid, output lock_state, output block_enable,
                  output state_changed, output status, output fail_count,
                  output success_count, input ready);
  modport sink   (input valid, input lock_state, input block_enable,
                  input state_changed, input status, input fail_count,
                  input success_count, output ready);
endinterface

>>> rtl/core/flc_cfg_regs.sv
// configuration register file
module flc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [flc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [flc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output flc_pkg::cfg_t                    cfg
);
  import flc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_CLOSED;
      cfg.start_blocked <= 1'b1;
      cfg.trip_limit    <= 8'd2;
      cfg.restore_limit <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:     cfg.mode          <= cfg_wdata[MODE_W-1:0];
        CFG_BUV:      cfg.start_blocked <= cfg_wdata[0];
        CFG_FAIL_THR: cfg.trip_limit    <= cfg_wdata[THRESH_W-1:0];
        CFG_SUCC_THR: cfg.restore_limit <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/flc_step.sv
// lock state, engage flag and run counters with their one-word update
module flc_step #(
  parameter int COUNT_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  flc_pkg::cfg_t cfg,
  input  logic          commit,
  input  flc_pkg::req_t item,
  output flc_pkg::rsp_t result
);
  import flc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

  logic                  armed;
  logic                  engaged;
  logic [LS_W-1:0]       lock_status;
  logic [COUNT_BITS-1:0] fail_run;
  logic [COUNT_BITS-1:0] success_run;

  logic                  armed_next;
  logic                  engaged_next;
  logic [LS_W-1:0]       lock_status_next;
  logic [COUNT_BITS-1:0] fail_run_next;
  logic [COUNT_BITS-1:0] success_run_next;

  logic [MODE_W-1:0]     eff_mode;
  logic                  blocking;
  logic                  err;
  logic                  changed;
  logic [COUNT_BITS-1:0] fail_inc;
  logic [COUNT_BITS-1:0] succ_inc;
  logic [CMP_W-1:0]      fail_ext;
  logic [CMP_W-1:0]      succ_ext;

  assign eff_mode = (cfg.mode > MODE_LEAKY) ? MODE_CLOSED : cfg.mode;
  assign blocking = (eff_mode == MODE_CLOSED) || (eff_mode == MODE_BACKUP);
  assign fail_inc = (&fail_run) ? fail_run : fail_run + 1'b1;
  assign succ_inc = (&success_run) ? success_run : success_run + 1'b1;

  always_comb begin
    armed_next       = armed;
    engaged_next     = engaged;
    lock_status_next = lock_status;
    fail_run_next    = fail_run;
    success_run_next = success_run;
    err              = 1'b0;
    changed          = 1'b0;
    case (item.req_type)
      REQ_ARM: begin
        armed_next       = 1'b1;
        fail_run_next    = '0;
        success_run_next = '0;
        if (eff_mode == MODE_OFF) begin
          engaged_next     = 1'b0;
          lock_status_next = LS_INACTIVE;
        end else if (blocking) begin
          if (engaged || item.engage_ok) begin
            engaged_next     = 1'b1;
            lock_status_next = cfg.start_blocked ? LS_TRIPPED : LS_HEALTHY;
          end else begin
            err              = 1'b1;
            lock_status_next = LS_OPEN;
          end
        end else begin
          engaged_next     = 1'b0;
          lock_status_next = LS_HEALTHY;
        end
      end
      REQ_DISARM: begin
        armed_next       = 1'b0;
        engaged_next     = 1'b0;
        lock_status_next = LS_INACTIVE;
      end
      REQ_REPORT: begin
        if (armed && (eff_mode != MODE_OFF)) begin
          if (item.healthy) begin
            success_run_next = succ_inc;
            fail_run_next    = '0;
          end else begin
            fail_run_next    = fail_inc;
            success_run_next = '0;
          end
          if (item.healthy && (lock_status != LS_HEALTHY) &&
              (CMP_W'(succ_inc) >= CMP_W'(cfg.restore_limit))) begin
            if (eff_mode == MODE_LEAKY) engaged_next = 1'b0;
            lock_status_next = LS_HEALTHY;
          end else if (!item.healthy && (lock_status == LS_HEALTHY) &&
                       (CMP_W'(fail_inc) >= CMP_W'(cfg.trip_limit))) begin
            if (blocking) begin
              if (engaged || item.engage_ok) begin
                engaged_next     = 1'b1;
                lock_status_next = (eff_mode == MODE_CLOSED) ? LS_TRIPPED : LS_FAILOVER;
              end else begin
                err              = 1'b1;
                lock_status_next = LS_OPEN;
              end
            end else begin
              engaged_next     = 1'b0;
              lock_status_next = LS_OPEN;
            end
          end
          changed = (lock_status_next != lock_status);
        end
      end
      default: ;
    endcase
  end

  // counts shown saturated at the output width
  assign fail_ext = CMP_W'(fail_run_next);
  assign succ_ext = CMP_W'(success_run_next);

  always_comb begin
    result.lock_state    = lock_status_next;
    result.block_enable  = engaged_next;
    result.state_changed = changed;
    result.status        = err;
    result.fail_count    = (fail_ext > CMP_W'({CNT_OUT_W{1'b1}})) ?
                           {CNT_OUT_W{1'b1}} : fail_ext[CNT_OUT_W-1:0];
    result.success_count = (succ_ext > CMP_W'({CNT_OUT_W{1'b1}})) ?
                           {CNT_OUT_W{1'b1}} : succ_ext[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      engaged     <= 1'b0;
      lock_status <= LS_INACTIVE;
      fail_run    <= '0;
      success_run <= '0;
    end else if (commit) begin
      armed       <= armed_next;
      engaged     <= engaged_next;
      lock_status <= lock_status_next;
      fail_run    <= fail_run_next;
      success_run <= success_run_next;
    end
  end

  a_engaged_needs_armed: assert property (@(posedge clk) disable iff (rst)
    engaged |-> armed)
    else $error("block engaged while disarmed");

  a_disarmed_inactive: assert property (@(posedge clk) disable iff (rst)
    !armed |-> (lock_status == LS_INACTIVE))
    else $error("lock state active while disarmed");

  a_open_not_engaged: assert property (@(posedge clk) disable iff (rst)
    (lock_status == LS_OPEN) |-> !engaged)
    else $error("failed open with block engaged");

  a_blocking_engaged: assert property (@(posedge clk) disable iff (rst)
    ((lock_status == LS_TRIPPED) || (lock_status == LS_FAILOVER)) |-> engaged)
    else $error("blocking state without engaged block");

  a_err_goes_open: assert property (@(posedge clk) disable iff (rst)
    (commit && err) |=> ((lock_status == LS_OPEN) && !engaged))
    else $error("failed engage did not fail open");

endmodule

>>> rtl/core/failover_lockdown_controller_core.sv
// top level of the failover lockdown controller
// Takes one request word per clock cycle while results are taken, and returns
// exactly one result word for each: the word is captured in an input register,
// the state update (armed, engaged, lock state, run counters) is done in one
// short combinational step, and the result lands in an output register when the
// update commits. While a result is stalled the update waits, one more request
// can still be held in the input register, and after that the request side
// stalls until the result is taken. Configuration is written through cfg_we,
// cfg_index and cfg_wdata; the user must write it only while no request is in
// flight, as the block does not enforce this. Counters are COUNT_BITS wide and
// saturate, and are reported clipped to 8 bits.
module failover_lockdown_controller_core #(
  parameter int COUNT_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [flc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  flc_req_if.sink                        req,
  flc_rsp_if.source                      rsp
);
  import flc_pkg::*;

  cfg_t cfg;
  req_t in_word;
  rsp_t step_result;
  rsp_t out_word;
  logic in_valid;
  logic out_valid;
  logic commit;

  assign commit    = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || commit;

  flc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  flc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .commit (commit),
    .item   (in_word),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_word.req_type  <= req.req_type;
      in_word.healthy   <= req.healthy;
      in_word.engage_ok <= req.engage_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_word <= step_result;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.lock_state    = out_word.lock_state;
  assign rsp.block_enable  = out_word.block_enable;
  assign rsp.state_changed = out_word.state_changed;
  assign rsp.status        = out_word.status;
  assign rsp.fail_count    = out_word.fail_count;
  assign rsp.success_count = out_word.success_count;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_word)))
    else $error("pending result overwritten");

  a_commit_needs_word: assert property (@(posedge clk) disable iff (rst)
    commit |-> in_valid)
    else $error("update without a captured word");

  a_change_only_on_report: assert property (@(posedge clk) disable iff (rst)
    (commit && (in_word.req_type != REQ_REPORT)) |=> !out_word.state_changed)
    else $error("state change flagged for a non-report word");

endmodule

>>> bench/flc_lock_checker.sv
// checker that predicts and compares result words of the failover lockdown controller
`timescale 1ns / 100ps

module flc_lock_checker
  import flc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  flc_req_if                    req_ch,
  flc_rsp_if                    rsp_ch,
  output int                    errors,
  output int                    outstanding
);

  logic [MODE_W-1:0]   mode_r;
  logic                buv_r;
  logic [THRESH_W-1:0] trip_thr;
  logic [THRESH_W-1:0] restore_thr;

  logic                armed_q;
  logic                engaged_q;
  logic [LS_W-1:0]     lock_q;
  logic [7:0]          fail_run_q;
  logic [7:0]          ok_run_q;

  rsp_t                due_words[$];
  int                  fail_total;

  function automatic logic [7:0] sat_up(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic rsp_t next_lock_word(input req_t w);
    logic [MODE_W-1:0] m;
    logic [LS_W-1:0]   prev;
    logic              err;
    logic              chg;
    rsp_t              r;
    m   = (mode_r > MODE_LEAKY) ? MODE_CLOSED : mode_r;
    err = 1'b0;
    chg = 1'b0;
    case (w.req_type)
      REQ_ARM: begin
        armed_q    = 1'b1;
        fail_run_q = '0;
        ok_run_q   = '0;
        if (m == MODE_OFF) begin
          engaged_q = 1'b0;
          lock_q    = LS_INACTIVE;
        end else if (m == MODE_CLOSED || m == MODE_BACKUP) begin
          if (!engaged_q && !w.engage_ok) begin
            err    = 1'b1;
            lock_q = LS_OPEN;
          end else begin
            engaged_q = 1'b1;
            lock_q    = buv_r ? LS_TRIPPED : LS_HEALTHY;
          end
        end else begin
          engaged_q = 1'b0;
          lock_q    = LS_HEALTHY;
        end
      end
      REQ_DISARM: begin
        armed_q   = 1'b0;
        engaged_q = 1'b0;
        lock_q    = LS_INACTIVE;
      end
      REQ_REPORT: begin
        if (armed_q && m != MODE_OFF) begin
          prev = lock_q;
          if (w.healthy) begin
            ok_run_q   = sat_up(ok_run_q);
            fail_run_q = '0;
          end else begin
            fail_run_q = sat_up(fail_run_q);
            ok_run_q   = '0;
          end
          if (w.healthy && lock_q != LS_HEALTHY && ok_run_q >= restore_thr) begin
            if (m == MODE_LEAKY) engaged_q = 1'b0;
            lock_q = LS_HEALTHY;
          end else if (!w.healthy && lock_q == LS_HEALTHY && fail_run_q >= trip_thr) begin
            if (m == MODE_CLOSED || m == MODE_BACKUP) begin
              if (!engaged_q && !w.engage_ok) begin
                err    = 1'b1;
                lock_q = LS_OPEN;
              end else begin
                engaged_q = 1'b1;
                lock_q    = (m == MODE_CLOSED) ? LS_TRIPPED : LS_FAILOVER;
              end
            end else begin
              engaged_q = 1'b0;
              lock_q    = LS_OPEN;
            end
          end
          chg = (lock_q != prev);
        end
      end
      default: ;
    endcase
    r.lock_state    = lock_q;
    r.block_enable  = engaged_q;
    r.state_changed = chg;
    r.status        = err;
    r.fail_count    = fail_run_q;
    r.success_count = ok_run_q;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    req_t w;
    rsp_t e;
    if (rst) begin
      mode_r      = MODE_CLOSED;
      buv_r       = 1'b1;
      trip_thr    = 8'd2;
      restore_thr = 8'd2;
      armed_q     = 1'b0;
      engaged_q   = 1'b0;
      lock_q      = LS_INACTIVE;
      fail_run_q  = '0;
      ok_run_q    = '0;
      due_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:     mode_r      = cfg_wdata[MODE_W-1:0];
          CFG_BUV:      buv_r       = cfg_wdata[0];
          CFG_FAIL_THR: trip_thr    = cfg_wdata[THRESH_W-1:0];
          CFG_SUCC_THR: restore_thr = cfg_wdata[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        w.req_type  = req_ch.req_type;
        w.healthy   = req_ch.healthy;
        w.engage_ok = req_ch.engage_ok;
        due_words.push_back(next_lock_word(w));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_words.size() == 0) begin
          $display("%0t: result word with none expected, actual lock_state %0d",
                   $time, rsp_ch.lock_state);
          fail_total++;
        end else begin
          e = due_words.pop_front();
          check_field("lock_state", e.lock_state, rsp_ch.lock_state);
          check_field("block_enable", e.block_enable, rsp_ch.block_enable);
          check_field("state_changed", e.state_changed, rsp_ch.state_changed);
          check_field("status", e.status, rsp_ch.status);
          check_field("fail_count", e.fail_count, rsp_ch.fail_count);
          check_field("success_count", e.success_count, rsp_ch.success_count);
        end
      end
    end
    outstanding = due_words.size();
  end

  initial begin
    fail_total = 0;
  end

  assign errors = fail_total;

endmodule

>>> bench/tb.sv
// stimulus, clock, reset and verdict for the failover lockdown controller
`timescale 1ns / 100ps

module tb;
  import flc_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    errors;
  int                    outstanding;

  logic idle_on;
  logic hold_go;
  logic run_healthy;
  int   hold_left;
  int   stall_left;

  flc_req_if req_ch ();
  flc_rsp_if rsp_ch ();

  failover_lockdown_controller_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  flc_lock_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .req_ch      (req_ch),
    .rsp_ch      (rsp_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send(input logic [REQ_W-1:0] rt, input logic h, input logic ok);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rt;
    req_ch.healthy   <= h;
    req_ch.engage_ok <= ok;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic end_phase();
    req_ch.valid <= 1'b0;
    for (int i = 0; i < 5000 && outstanding != 0; i++) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_thr();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, 4));
  endfunction

  task automatic random_item();
    int               r;
    logic [REQ_W-1:0] rt;
    r = $urandom_range(0, 99);
    if (r < 8) rt = REQ_ARM;
    else if (r < 12) rt = REQ_DISARM;
    else if (r < 15) rt = REQ_UNUSED;
    else rt = REQ_REPORT;
    if ($urandom_range(0, 3) == 0) run_healthy = ~run_healthy;
    send(rt, (rt == REQ_REPORT) ? run_healthy : 1'($urandom_range(0, 1)),
         ($urandom_range(0, 4) != 0));
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_REPORT;
    req_ch.healthy   = 1'b0;
    req_ch.engage_ok = 1'b0;
    idle_on          = 1'b1;
    hold_go          = 1'b0;
    run_healthy      = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: fail closed, start tripped, thresholds of two
    send(REQ_REPORT, 1'b0, 1'b1);
    send(REQ_UNUSED, 1'b1, 1'b1);
    send(REQ_ARM, 1'b0, 1'b0);
    send(REQ_ARM, 1'b1, 1'b1);
    send(REQ_REPORT, 1'b1, 1'b0);
    send(REQ_REPORT, 1'b1, 1'b0);
    send(REQ_REPORT, 1'b0, 1'b0);
    send(REQ_REPORT, 1'b0, 1'b0);
    send(REQ_UNUSED, 1'b0, 1'b0);
    send(REQ_DISARM, 1'b0, 1'b1);
    send(REQ_REPORT, 1'b1, 1'b1);
    end_phase();

    write_reg(CFG_BUV, 8'd0);
    write_reg(CFG_MODE, 8'(MODE_BACKUP));
    send(REQ_ARM, 1'b1, 1'b0);
    send(REQ_REPORT, 1'b1, 1'b0);
    send(REQ_REPORT, 1'b1, 1'b0);
    send(REQ_REPORT, 1'b0, 1'b0);
    send(REQ_REPORT, 1'b0, 1'b0);
    send(REQ_REPORT, 1'b1, 1'b1);
    send(REQ_REPORT, 1'b1, 1'b1);
    send(REQ_REPORT, 1'b0, 1'b1);
    send(REQ_REPORT, 1'b0, 1'b1);
    end_phase();

    // mode changes while armed take effect on reports
    write_reg(CFG_MODE, 8'(MODE_LEAKY));
    send(REQ_REPORT, 1'b1, 1'b0);
    send(REQ_REPORT, 1'b1, 1'b0);
    end_phase();
    write_reg(CFG_MODE, 8'(MODE_OFF));
    send(REQ_REPORT, 1'b0, 1'b1);
    end_phase();

    write_reg(CFG_FAIL_THR, 8'd0);
    write_reg(CFG_SUCC_THR, 8'd0);
    write_reg(CFG_MODE, 8'(MODE_LEAKY));
    send(REQ_ARM, 1'b0, 1'b1);
    send(REQ_REPORT, 1'b0, 1'b1);
    send(REQ_REPORT, 1'b1, 1'b1);
    end_phase();

    // saturating counters against the largest trip threshold
    write_reg(CFG_MODE, 8'(MODE_CLOSED));
    write_reg(CFG_FAIL_THR, 8'd255);
    write_reg(CFG_SUCC_THR, 8'd3);
    send(REQ_ARM, 1'b1, 1'b1);
    repeat (257) send(REQ_REPORT, 1'b0, 1'($urandom_range(0, 1)));
    repeat (3) send(REQ_REPORT, 1'b1, 1'($urandom_range(0, 1)));
    end_phase();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) idle_on = 1'b0;
      write_reg(CFG_MODE, 8'($urandom_range(0, 7)));
      write_reg(CFG_BUV, 8'($urandom_range(0, 1)));
      write_reg(CFG_FAIL_THR, pick_thr());
      write_reg(CFG_SUCC_THR, pick_thr());
      send(REQ_ARM, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0));
      if (ph == 2) begin
        idle_on = 1'b0;
        hold_go = 1'b1;
        repeat (20) random_item();
        idle_on = 1'b1;
      end
      repeat (20) random_item();
      end_phase();
    end

    repeat (10) @(negedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected result words never arrived", $time, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
